// ===== src/char_list_engine_defines.svh =====
// Assertion macros used by the checker file of the list engine.
`ifndef CHAR_LIST_ENGINE_DEFINES_SVH
`define CHAR_LIST_ENGINE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define CLE_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("list engine check failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define CLE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("list engine check failed");

`endif

// ===== src/cle_pkg.sv =====
// Types, field widths and operation codes of the character list engine.
`timescale 1ns / 1ps

package cle_pkg;

   localparam int CAPACITY_DEFAULT = 64;

   localparam int KIND_W   = 4;
   localparam int CHAR_W   = 8;
   localparam int POS_W    = 7;
   localparam int COUNT_W  = 7;
   localparam int STATUS_W = 2;

   // Operation codes carried in the kind field
   localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 4'd0;
   localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 4'd1;
   localparam logic [KIND_W-1:0] KIND_INSERT_AT  = 4'd2;
   localparam logic [KIND_W-1:0] KIND_SORTED_INS = 4'd3;
   localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 4'd4;
   localparam logic [KIND_W-1:0] KIND_POP_BACK   = 4'd5;
   localparam logic [KIND_W-1:0] KIND_REMOVE_AT  = 4'd6;
   localparam logic [KIND_W-1:0] KIND_REPLACE    = 4'd7;
   localparam logic [KIND_W-1:0] KIND_READ       = 4'd8;
   localparam logic [KIND_W-1:0] KIND_CLEAR      = 4'd9;

   // Result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd3;

   typedef struct packed {
      logic [KIND_W-1:0]        kind;
      logic signed [CHAR_W-1:0] ch;
      logic [POS_W-1:0]         position;
   } req_type;

   typedef struct packed {
      logic signed [CHAR_W-1:0] data_out;
      logic [COUNT_W-1:0]       count_out;
      logic [STATUS_W-1:0]      status;
   } rsp_type;

endpackage

// ===== src/cle_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read data.
`timescale 1ns / 1ps

module cle_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write when enabled, read every cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/char_list_engine.sv =====
// Top level of the character list engine: sequencer, pointer unit and entry store.
`timescale 1ns / 1ps

// Ordered list of up to CAPACITY signed characters held in one RAM with a
// count register. One request beat is taken at a time; req_ready is high only
// while the sequencer is idle. Replace, clear, errors and unused codes go from
// the check straight to the response; push back writes with no shift. All
// else walks entries through the RAM's registered read port with a shared
// add/subtract and an incrementer, a read and a write state per entry moved
// and a read and a compare state per entry scanned: insert at p and remove at
// p (and pop front or back) shift the tail, read fetches one entry, sorted
// insert scans to the slot, then shifts the tail. A finished response sits in
// an output register, so the next request is taken while the response waits
// for rsp_ready. The store has no reset; only entries below the count are used.
module char_list_engine #(
   parameter int CAPACITY = cle_pkg::CAPACITY_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  cle_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output cle_pkg::rsp_type rsp_data
);

   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int ADDR_W = $clog2(CAPACITY);
   localparam int CMP_W  = (CNT_W > cle_pkg::POS_W) ? CNT_W : cle_pkg::POS_W;

   typedef enum logic [10:0] {
      S_IDLE     = 11'b000_0000_0001,
      S_CHECK    = 11'b000_0000_0010,
      S_SCAN_RD  = 11'b000_0000_0100,
      S_SCAN_CMP = 11'b000_0000_1000,
      S_SH_RD    = 11'b000_0001_0000,
      S_SH_WR    = 11'b000_0010_0000,
      S_FETCH    = 11'b000_0100_0000,
      S_TAKE     = 11'b000_1000_0000,
      S_RM_RD    = 11'b001_0000_0000,
      S_RM_WR    = 11'b010_0000_0000,
      S_DONE     = 11'b100_0000_0000
   } state_type;

   state_type                         state_ff, state_in;
   logic [cle_pkg::KIND_W-1:0]        kind_ff, kind_in;
   logic signed [cle_pkg::CHAR_W-1:0] ch_ff, ch_in;
   logic [cle_pkg::POS_W-1:0]         pos_ff, pos_in;
   logic [CNT_W-1:0]                  count_ff, count_in;
   logic [CNT_W-1:0]                  ptr_ff, ptr_in;
   logic [CNT_W-1:0]                  tgt_ff, tgt_in;
   logic [cle_pkg::CHAR_W-1:0]        data_ff, data_in;
   logic [cle_pkg::STATUS_W-1:0]      status_ff, status_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   cle_pkg::rsp_type                  rsp_ff, rsp_in;

   // Pointer unit: one add/subtract, one incrementer and the compares
   logic             ptr_down;
   logic [CNT_W-1:0] ptr_step;
   logic [CNT_W-1:0] ptr_plus;
   logic [CMP_W-1:0] pos_ext;
   logic [CMP_W-1:0] cnt_ext;
   logic             full;
   logic             empty;

   // RAM port controls
   logic                       ram_wr_en;
   logic [ADDR_W-1:0]          ram_wr_addr;
   logic [cle_pkg::CHAR_W-1:0] ram_wr_data;
   logic [ADDR_W-1:0]          ram_rd_addr;
   logic [cle_pkg::CHAR_W-1:0] ram_rd_data;

   cle_ram #(
      .WIDTH (cle_pkg::CHAR_W),
      .DEPTH (CAPACITY)
   ) u_cle_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign ptr_down = (state_ff == S_SH_RD) || (state_ff == S_SH_WR);
   assign ptr_step = ptr_down ? (ptr_ff - CNT_W'(1)) : (ptr_ff + CNT_W'(1));
   assign ptr_plus = ptr_ff + CNT_W'(1);
   assign pos_ext  = CMP_W'(pos_ff);
   assign cnt_ext  = CMP_W'(count_ff);
   assign full     = (count_ff == CNT_W'(CAPACITY));
   assign empty    = (count_ff == '0);

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      ch_in        = ch_ff;
      pos_in       = pos_ff;
      count_in     = count_ff;
      ptr_in       = ptr_ff;
      tgt_in       = tgt_ff;
      data_in      = data_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = ptr_ff[ADDR_W-1:0];
      ram_wr_data  = ram_rd_data;
      ram_rd_addr  = ptr_ff[ADDR_W-1:0];

      // Drop the response once taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               kind_in  = req_data.kind;
               ch_in    = req_data.ch;
               pos_in   = req_data.position;
               state_in = S_CHECK;
            end
         end

         S_CHECK: begin
            data_in   = '0;
            status_in = cle_pkg::STATUS_OK;
            state_in  = S_DONE;
            unique case (kind_ff) inside
               cle_pkg::KIND_PUSH_BACK: begin
                  if (full) begin
                     status_in = cle_pkg::STATUS_FULL;
                  end else begin
                     tgt_in   = count_ff;
                     ptr_in   = count_ff;
                     state_in = S_SH_RD;
                  end
               end
               cle_pkg::KIND_PUSH_FRONT: begin
                  if (full) begin
                     status_in = cle_pkg::STATUS_FULL;
                  end else begin
                     tgt_in   = '0;
                     ptr_in   = count_ff;
                     state_in = S_SH_RD;
                  end
               end
               cle_pkg::KIND_INSERT_AT: begin
                  if (pos_ext > cnt_ext) begin
                     status_in = cle_pkg::STATUS_RANGE;
                  end else if (full) begin
                     status_in = cle_pkg::STATUS_FULL;
                  end else begin
                     tgt_in   = CNT_W'(pos_ff);
                     ptr_in   = count_ff;
                     state_in = S_SH_RD;
                  end
               end
               cle_pkg::KIND_SORTED_INS: begin
                  if (full) begin
                     status_in = cle_pkg::STATUS_FULL;
                  end else begin
                     ptr_in   = '0;
                     state_in = S_SCAN_RD;
                  end
               end
               cle_pkg::KIND_POP_FRONT: begin
                  if (empty) begin
                     status_in = cle_pkg::STATUS_EMPTY;
                  end else begin
                     tgt_in   = '0;
                     state_in = S_FETCH;
                  end
               end
               cle_pkg::KIND_POP_BACK: begin
                  if (empty) begin
                     status_in = cle_pkg::STATUS_EMPTY;
                  end else begin
                     tgt_in   = count_ff - CNT_W'(1);
                     state_in = S_FETCH;
                  end
               end
               cle_pkg::KIND_REMOVE_AT, cle_pkg::KIND_READ: begin
                  if (pos_ext >= cnt_ext) begin
                     status_in = cle_pkg::STATUS_RANGE;
                  end else begin
                     tgt_in   = CNT_W'(pos_ff);
                     state_in = S_FETCH;
                  end
               end
               cle_pkg::KIND_REPLACE: begin
                  if (pos_ext >= cnt_ext) begin
                     status_in = cle_pkg::STATUS_RANGE;
                  end else begin
                     ram_wr_en   = 1'b1;
                     ram_wr_addr = ADDR_W'(pos_ff);
                     ram_wr_data = ch_ff;
                  end
               end
               cle_pkg::KIND_CLEAR: begin
                  count_in = '0;
               end
               default: begin
               end
            endcase
         end

         // Walk forward while the new character is not below the entry
         S_SCAN_RD: begin
            if (ptr_ff < count_ff) begin
               state_in = S_SCAN_CMP;
            end else begin
               tgt_in   = ptr_ff;
               state_in = S_SH_RD;
            end
         end

         S_SCAN_CMP: begin
            if (ch_ff >= $signed(ram_rd_data)) begin
               ptr_in   = ptr_step;
               state_in = S_SCAN_RD;
            end else begin
               tgt_in   = ptr_ff;
               ptr_in   = count_ff;
               state_in = S_SH_RD;
            end
         end

         // Shift the tail up one slot, then drop the character into the hole
         S_SH_RD: begin
            ram_rd_addr = ptr_step[ADDR_W-1:0];
            if (ptr_ff > tgt_ff) begin
               state_in = S_SH_WR;
            end else begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = tgt_ff[ADDR_W-1:0];
               ram_wr_data = ch_ff;
               count_in    = count_ff + CNT_W'(1);
               state_in    = S_DONE;
            end
         end

         S_SH_WR: begin
            ram_wr_en = 1'b1;
            ptr_in    = ptr_step;
            state_in  = S_SH_RD;
         end

         S_FETCH: begin
            ram_rd_addr = tgt_ff[ADDR_W-1:0];
            state_in    = S_TAKE;
         end

         S_TAKE: begin
            data_in = ram_rd_data;
            ptr_in  = tgt_ff;
            if (kind_ff == cle_pkg::KIND_READ) begin
               state_in = S_DONE;
            end else begin
               state_in = S_RM_RD;
            end
         end

         // Shift the tail down one slot over the removed entry
         S_RM_RD: begin
            ram_rd_addr = ptr_plus[ADDR_W-1:0];
            if (ptr_plus < count_ff) begin
               state_in = S_RM_WR;
            end else begin
               count_in = count_ff - CNT_W'(1);
               state_in = S_DONE;
            end
         end

         S_RM_WR: begin
            ram_wr_en = 1'b1;
            ptr_in    = ptr_step;
            state_in  = S_RM_RD;
         end

         // Hand the result to the output register once it is free
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.data_out  = data_ff;
               rsp_in.count_out = cnt_ext[cle_pkg::COUNT_W-1:0];
               rsp_in.status    = status_ff;
               rsp_valid_in     = 1'b1;
               state_in         = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and working registers
   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      ch_ff     <= ch_in;
      pos_ff    <= pos_in;
      ptr_ff    <= ptr_in;
      tgt_ff    <= tgt_in;
      data_ff   <= data_in;
      status_ff <= status_in;
      rsp_ff    <= rsp_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== src/cle_checker.sv =====
// Port-level checks of the character list engine, bound to its top level.
`timescale 1ns / 1ps
`include "char_list_engine_defines.svh"

module cle_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input cle_pkg::rsp_type rsp_data
);

   // A stalled response beat holds its payload
   `CLE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

   // One request at a time: the engine is busy right after taking a beat
   `CLE_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready)

   // A failed operation returns no character
   `CLE_ASSERT_NOW(a_err_no_data, clock, reset, rsp_valid && (rsp_data.status != cle_pkg::STATUS_OK), rsp_data.data_out == '0)

   // An empty report always comes with an empty list
   `CLE_ASSERT_NOW(a_empty_count, clock, reset, rsp_valid && (rsp_data.status == cle_pkg::STATUS_EMPTY), rsp_data.count_out == '0)

endmodule

bind char_list_engine cle_checker u_cle_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the character list engine: directed, full-list, stall and random ops.
`timescale 1ns / 1ps

module tb;
   import cle_pkg::*;

   localparam int CAPACITY     = CAPACITY_DEFAULT;
   localparam int RANDOM_ITEMS = 1630;
   localparam int SEGMENT_LEN  = 150;
   localparam int MAX_GAP      = 10;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // Software copy of the list contents and length
   logic signed [CHAR_W-1:0] list_mem [CAPACITY];
   int unsigned              list_len;

   rsp_type list_expect_q [$];
   int      mismatch_count  = 0;
   bit      gaps_enabled    = 1'b1;
   int      rsp_hold_cycles = 0;

   char_list_engine #(.CAPACITY(CAPACITY)) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Open a hole at the given index and place the character there
   function automatic void open_slot(input int unsigned at, input logic signed [CHAR_W-1:0] v);
      for (int unsigned i = list_len; i > at; i--) begin
         list_mem[i] = list_mem[i-1];
      end
      list_mem[at] = v;
      list_len++;
   endfunction

   // Remove the entry at the given index and close the gap
   function automatic logic signed [CHAR_W-1:0] close_slot(input int unsigned at);
      logic signed [CHAR_W-1:0] v;
      v = list_mem[at];
      for (int unsigned i = at; i + 1 < list_len; i++) begin
         list_mem[i] = list_mem[i+1];
      end
      list_len--;
      return v;
   endfunction

   // Apply one operation to the list copy and return the response it yields
   function automatic rsp_type predict_list_op(input req_type op);
      rsp_type     res;
      int unsigned p;
      int unsigned idx;
      bit          is_full;
      res     = '0;
      p       = op.position;
      is_full = (list_len >= CAPACITY);
      res.status = STATUS_OK;
      case (op.kind)
         KIND_PUSH_BACK: begin
            if (is_full) res.status = STATUS_FULL;
            else open_slot(list_len, op.ch);
         end
         KIND_PUSH_FRONT: begin
            if (is_full) res.status = STATUS_FULL;
            else open_slot(0, op.ch);
         end
         KIND_INSERT_AT: begin
            if (p > list_len) res.status = STATUS_RANGE;
            else if (is_full) res.status = STATUS_FULL;
            else open_slot(p, op.ch);
         end
         KIND_SORTED_INS: begin
            if (is_full) begin
               res.status = STATUS_FULL;
            end else begin
               // Land after every entry less than or equal to the new one
               idx = 0;
               while (idx < list_len && $signed(op.ch) >= $signed(list_mem[idx])) idx++;
               open_slot(idx, op.ch);
            end
         end
         KIND_POP_FRONT: begin
            if (list_len == 0) res.status = STATUS_EMPTY;
            else res.data_out = close_slot(0);
         end
         KIND_POP_BACK: begin
            if (list_len == 0) res.status = STATUS_EMPTY;
            else res.data_out = close_slot(list_len - 1);
         end
         KIND_REMOVE_AT: begin
            if (p >= list_len) res.status = STATUS_RANGE;
            else res.data_out = close_slot(p);
         end
         KIND_REPLACE: begin
            if (p >= list_len) res.status = STATUS_RANGE;
            else list_mem[p] = op.ch;
         end
         KIND_READ: begin
            if (p >= list_len) res.status = STATUS_RANGE;
            else res.data_out = list_mem[p];
         end
         KIND_CLEAR: begin
            list_len = 0;
         end
         default: begin
         end
      endcase
      res.count_out = COUNT_W'(list_len);
      return res;
   endfunction

   // Offer one beat after a random gap, record its expected response on accept
   task automatic send_beat(input req_type item);
      int gap;
      gap = gaps_enabled ? $urandom_range(MAX_GAP, 0) : 0;
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data  = item;
      req_valid = 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      list_expect_q.push_back(predict_list_op(item));
      @(negedge clock);
   endtask

   task automatic send_op(input logic [KIND_W-1:0] kind, input int ch, input int pos);
      req_type item;
      item.kind     = kind;
      item.ch       = CHAR_W'(ch);
      item.position = POS_W'(pos);
      send_beat(item);
   endtask

   // Drop valid and hold until every expected response has come back
   task automatic drain_results();
      req_valid = 1'b0;
      while (list_expect_q.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // Build one op: mostly well-formed for the current length, some noise
   function automatic req_type random_list_op(input int unsigned target_len);
      req_type op;
      int      r;
      bit      grow;
      r = $urandom_range(99, 0);
      op.ch = ($urandom_range(3, 0) == 0) ? CHAR_W'($urandom_range(3, 0)) : CHAR_W'($urandom);
      op.position = '0;
      if (r < 3) begin
         op.kind     = KIND_W'($urandom_range(2**KIND_W - 1, KIND_CLEAR + 1));
         op.position = POS_W'($urandom);
      end else if (r < 10) begin
         op.kind     = KIND_W'($urandom_range(KIND_CLEAR, KIND_PUSH_BACK));
         op.position = POS_W'($urandom);
      end else if (r < 11) begin
         op.kind = KIND_CLEAR;
      end else begin
         grow = (list_len < target_len) ? ($urandom_range(9, 0) < 7) : ($urandom_range(9, 0) < 3);
         if (grow) begin
            case ($urandom_range(3, 0))
               0:       op.kind = KIND_PUSH_BACK;
               1:       op.kind = KIND_PUSH_FRONT;
               2:       op.kind = KIND_INSERT_AT;
               default: op.kind = KIND_SORTED_INS;
            endcase
            op.position = POS_W'($urandom_range(list_len, 0));
         end else begin
            case ($urandom_range(4, 0))
               0:       op.kind = KIND_POP_FRONT;
               1:       op.kind = KIND_POP_BACK;
               2:       op.kind = KIND_REMOVE_AT;
               3:       op.kind = KIND_REPLACE;
               default: op.kind = KIND_READ;
            endcase
            op.position = (list_len > 0) ? POS_W'($urandom_range(list_len - 1, 0)) : '0;
         end
      end
      return op;
   endfunction

   // Errors on an empty list, extremes of the character, sorted ties, clear
   task automatic test_directed_ops();
      send_op(KIND_POP_FRONT,  0, 0);
      send_op(KIND_POP_BACK,   0, 0);
      send_op(KIND_READ,       0, 0);
      send_op(KIND_REMOVE_AT,  0, 0);
      send_op(KIND_REPLACE,    1, 0);
      send_op(KIND_INSERT_AT,  1, 1);
      send_op(KIND_INSERT_AT,  1, 2**POS_W - 1);
      send_op(KIND_INSERT_AT,  5, 0);
      send_op(KIND_PUSH_BACK,  127, 0);
      send_op(KIND_PUSH_FRONT, -128, 0);
      send_op(KIND_SORTED_INS, 5, 0);
      send_op(KIND_SORTED_INS, -128, 0);
      send_op(KIND_SORTED_INS, 127, 0);
      send_op(KIND_SORTED_INS, 0, 0);
      send_op(KIND_READ,       0, 3);
      send_op(KIND_REPLACE,    -1, 2);
      send_op(KIND_READ,       0, 2);
      send_op(KIND_REMOVE_AT,  0, 1);
      send_op(KIND_POP_BACK,   0, 0);
      send_op(KIND_POP_FRONT,  0, 0);
      send_op(KIND_READ,       0, CAPACITY);
      send_op(KIND_W'(2**KIND_W - 1), -1, 2**POS_W - 1);
      send_op(KIND_CLEAR,      0, 0);
      send_op(KIND_POP_FRONT,  0, 0);
      drain_results();
   endtask

   // Fill to capacity, hit every full case and the insert and remove range cases, then work at the ends
   task automatic test_full_list();
      send_op(KIND_CLEAR, 0, 0);
      for (int i = 0; i < CAPACITY; i++) send_op(KIND_PUSH_BACK, $urandom, 0);
      send_op(KIND_PUSH_BACK,  1, 0);
      send_op(KIND_PUSH_FRONT, 1, 0);
      send_op(KIND_SORTED_INS, 1, 0);
      send_op(KIND_INSERT_AT,  1, CAPACITY);
      send_op(KIND_INSERT_AT,  1, CAPACITY + 1);
      send_op(KIND_INSERT_AT,  1, 0);
      send_op(KIND_READ,       0, CAPACITY - 1);
      send_op(KIND_REPLACE,    -7, CAPACITY - 1);
      send_op(KIND_REMOVE_AT,  0, CAPACITY);
      send_op(KIND_REMOVE_AT,  0, 0);
      send_op(KIND_INSERT_AT,  3, 0);
      send_op(KIND_POP_BACK,   0, 0);
      send_op(KIND_SORTED_INS, -128, 0);
      send_op(KIND_CLEAR,      0, 0);
      drain_results();
   endtask

   // Stall responses for a long stretch while requests keep coming
   task automatic test_backpressure();
      gaps_enabled    = 1'b0;
      rsp_hold_cycles = 300;
      for (int i = 0; i < 12; i++) begin
         send_op((i % 3 == 2) ? KIND_READ : KIND_PUSH_BACK, $urandom, 0);
      end
      drain_results();
      gaps_enabled = 1'b1;
   endtask

   // Random ops in segments, each with its own length target and gap mode
   task automatic test_random_ops();
      int unsigned target_len;
      target_len = 8;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % SEGMENT_LEN == 0) begin
            target_len   = ($urandom_range(9, 0) == 0) ? CAPACITY : $urandom_range(20, 1);
            gaps_enabled = ($urandom_range(3, 0) != 0);
         end
         if (n % 400 == 399) drain_results();
         send_beat(random_list_op(target_len));
      end
      drain_results();
   endtask

   // Response side: random stall per beat, plus an occasional long hold-off
   initial begin
      int stall;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (rsp_hold_cycles > 0) begin
            rsp_ready = 1'b0;
            repeat (rsp_hold_cycles) @(negedge clock);
            rsp_hold_cycles = 0;
         end
         stall = gaps_enabled ? $urandom_range(MAX_GAP, 0) : 0;
         if (stall > 0) begin
            rsp_ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready = 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         @(negedge clock);
      end
   end

   // Compare each response beat with the oldest expectation
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (list_expect_q.size() == 0) begin
            $error("response beat with no expected result");
            mismatch_count++;
         end else begin
            want = list_expect_q.pop_front();
            if (rsp_data.data_out !== want.data_out) begin
               $error("data_out: expected %0d, actual %0d", want.data_out, rsp_data.data_out);
               mismatch_count++;
            end
            if (rsp_data.count_out !== want.count_out) begin
               $error("count_out: expected %0d, actual %0d", want.count_out, rsp_data.count_out);
               mismatch_count++;
            end
            if (rsp_data.status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_data.status);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      list_len = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed_ops();
      test_full_list();
      test_backpressure();
      test_random_ops();
      // Let any stray response show up before the verdict
      repeat (2 * CAPACITY + 10) @(posedge clock);
      if (mismatch_count == 0 && list_expect_q.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // Stop a hung run
   initial begin
      #30_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
